[rtl/fir20_pkg.sv]
`default_nettype none
package fir20_pkg;

	localparam int TAPS        = 20;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int COEF_REGS   = 5;
	localparam int COEFS_PER_REG = 4;
	localparam int REG_BITS    = COEF_BITS * COEFS_PER_REG;
	localparam int FRAC_SHIFT  = 15;

	localparam int CFG_ADDR_BITS = $clog2(COEF_REGS);
	localparam int TAP_BITS      = $clog2(TAPS);
	localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS      = PROD_BITS + $clog2(TAPS);
	localparam int SHIFT_BITS    = ACC_BITS - FRAC_SHIFT;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                load;
		logic                mul_en;
		logic                acc_en;
		logic                out_load;
		logic [TAP_BITS-1:0] tap;
	} cmd_t;

endpackage
`default_nettype wire

[rtl/fir20_ctrl.sv]
`default_nettype none
module fir20_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output fir20_pkg::cmd_t      cmd
);

	localparam logic [fir20_pkg::TAP_BITS-1:0] LAST_TAP =
		fir20_pkg::TAP_BITS'(fir20_pkg::TAPS - 1);

	fir20_pkg::state_t state_q, state_d;
	logic [fir20_pkg::TAP_BITS-1:0] tap_q;
	logic out_valid_q;
	logic accept;

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fir20_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = fir20_pkg::ST_MAC;
			end
			fir20_pkg::ST_MAC: begin
				if (tap_q == LAST_TAP) state_d = fir20_pkg::ST_DRAIN;
			end
			fir20_pkg::ST_DRAIN: begin
				state_d = fir20_pkg::ST_RESULT;
			end
			fir20_pkg::ST_RESULT: begin
				if (!out_valid_q || m_tready) state_d = fir20_pkg::ST_IDLE;
			end
			default: begin
				state_d = fir20_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.acc_en   = 1'b0;
		cmd.out_load = 1'b0;
		cmd.tap      = tap_q;
		case (state_q)
			fir20_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			fir20_pkg::ST_MAC: begin
				cmd.mul_en = 1'b1;
				// the product of the previous tap is registered in prod_s1 and summed here
				cmd.acc_en = (tap_q != '0);
			end
			fir20_pkg::ST_DRAIN: begin
				cmd.acc_en = 1'b1;
			end
			fir20_pkg::ST_RESULT: begin
				cmd.out_load = !out_valid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fir20_pkg::ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) tap_q <= '0;
			else if (cmd.mul_en && tap_q != LAST_TAP) tap_q <= tap_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

[rtl/fir20_dp.sv]
`default_nettype none
module fir20_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [fir20_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  wire logic [fir20_pkg::REG_BITS-1:0]        cfg_data,
	input  wire logic [fir20_pkg::SAMPLE_BITS-1:0]     sample_in,
	input  wire logic                                  buffer_end,
	input  wire fir20_pkg::cmd_t                       cmd,
	output logic [fir20_pkg::SAMPLE_BITS-1:0]          sample_out,
	output logic                                       buffer_end_out
);

	localparam int SB = fir20_pkg::SAMPLE_BITS;
	localparam int CB = fir20_pkg::COEF_BITS;
	localparam logic signed [fir20_pkg::SHIFT_BITS-1:0] SAT_HI =
		fir20_pkg::SHIFT_BITS'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [fir20_pkg::SHIFT_BITS-1:0] SAT_LO =
		fir20_pkg::SHIFT_BITS'(-(64'sd1 <<< (SB - 1)));
	localparam logic signed [fir20_pkg::ACC_BITS-1:0] ROUND_HALF =
		fir20_pkg::ACC_BITS'(64'sd1 <<< (fir20_pkg::FRAC_SHIFT - 1));

	logic [fir20_pkg::REG_BITS-1:0]               coef_q [fir20_pkg::COEF_REGS];
	logic signed [CB-1:0]                         coef_tap [fir20_pkg::TAPS];
	logic signed [SB-1:0]                         line_q [fir20_pkg::TAPS];
	logic                                         last_q;
	logic signed [fir20_pkg::PROD_BITS-1:0]       prod_s1;
	logic signed [fir20_pkg::ACC_BITS-1:0]        acc_q;
	logic signed [fir20_pkg::ACC_BITS-1:0]        rounded;
	logic signed [fir20_pkg::SHIFT_BITS-1:0]      shifted;
	logic signed [SB-1:0]                         sat;
	logic [SB-1:0]                                out_data_q;
	logic                                         out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fir20_pkg::COEF_REGS; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			// indexes past the last register drop the write
			for (int i = 0; i < fir20_pkg::COEF_REGS; i++)
				if (cfg_addr == fir20_pkg::CFG_ADDR_BITS'(i)) coef_q[i] <= cfg_data;
		end
	end

	for (genvar t = 0; t < fir20_pkg::TAPS; t++) begin : g_coef
		if (t / fir20_pkg::COEFS_PER_REG < fir20_pkg::COEF_REGS) begin : g_reg
			assign coef_tap[t] = coef_q[t / fir20_pkg::COEFS_PER_REG]
				[(t % fir20_pkg::COEFS_PER_REG) * CB +: CB];
		end else begin : g_zero
			assign coef_tap[t] = '0;
		end
	end

	// entry 0 holds the newest sample once it is taken in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fir20_pkg::TAPS; i++) line_q[i] <= '0;
		end else if (cmd.load) begin
			line_q[0] <= sample_in;
			for (int i = 1; i < fir20_pkg::TAPS; i++) line_q[i] <= line_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) last_q <= buffer_end;
		if (cmd.mul_en) prod_s1 <= coef_tap[cmd.tap] * line_q[cmd.tap];
		if (cmd.load) acc_q <= '0;
		else if (cmd.acc_en) acc_q <= acc_q + fir20_pkg::ACC_BITS'(prod_s1);
		if (cmd.out_load) begin
			out_data_q <= sat;
			out_last_q <= last_q;
		end
	end

	always_comb begin
		rounded = acc_q + ROUND_HALF;
		shifted = fir20_pkg::SHIFT_BITS'(rounded >>> fir20_pkg::FRAC_SHIFT);
		if (shifted > SAT_HI) sat = SB'(SAT_HI);
		else if (shifted < SAT_LO) sat = SB'(SAT_LO);
		else sat = SB'(shifted);
	end

	assign sample_out     = out_data_q;
	assign buffer_end_out = out_last_q;

endmodule
`default_nettype wire

[rtl/fir_filter_twenty_tap.sv]
// Twenty-tap direct-form FIR filter for a stream of 16-bit audio samples.
// Input stream (s_*): tdata carries one signed Q1.15 sample, tlast marks
// the last sample of a software buffer and is passed to m_tlast unchanged.
// Output stream (m_*): tdata carries the filtered sample, rounded half up,
// shifted right by 15 and saturated to 16 bits; one output word per input.
// Coefficients: five 64-bit registers written over cfg_we/cfg_addr/cfg_data,
// four signed Q1.15 taps each, lowest tap in the low bits; write them only
// while the filter is idle. Writes to indexes 5 and up are ignored.
// Timing: one shared 16x16 multiplier walks the twenty taps, one per cycle.
// A word is taken in ST_IDLE; ST_MAC then walks the taps, ST_DRAIN adds the last
// product and ST_RESULT loads the output register, which raises m_tvalid. The
// next word is taken only once the block is back in ST_IDLE, not during a run.
// The output register decouples the sides: the next word is accepted while
// a result waits; if the receiver stalls longer, the block holds the new
// result internally and stops taking words until the output frees up.
// Reset clears coefficients, the delay line and all handshake state.
`default_nettype none
module fir_filter_twenty_tap (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [fir20_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  wire logic [fir20_pkg::REG_BITS-1:0]       cfg_data,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [fir20_pkg::SAMPLE_BITS-1:0]    s_tdata,  // [15:0] sample_in
	input  wire logic                                 s_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [fir20_pkg::SAMPLE_BITS-1:0]         m_tdata,  // [15:0] sample_out
	output logic                                      m_tlast
);

	fir20_pkg::cmd_t cmd;

	fir20_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	fir20_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.sample_in      (s_tdata),
		.buffer_end     (s_tlast),
		.cmd            (cmd),
		.sample_out     (m_tdata),
		.buffer_end_out (m_tlast)
	);

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_PHASES = 6;

	typedef enum int {
		REG_TAPS_0_3,
		REG_TAPS_4_7,
		REG_TAPS_8_11,
		REG_TAPS_12_15,
		REG_TAPS_16_19
	} coef_reg_t;

	typedef enum int {
		SET_IMPULSE,
		SET_HALF,
		SET_MAX_POS,
		SET_MAX_NEG,
		SET_GENTLE,
		SET_RANDOM
	} coef_style_t;

	typedef struct {
		logic [fir20_pkg::SAMPLE_BITS-1:0] sample;
		logic                              last;
	} audio_word_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [fir20_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
	logic [fir20_pkg::REG_BITS-1:0]      cfg_data = '0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [fir20_pkg::SAMPLE_BITS-1:0]   s_tdata = '0;   // [15:0] sample_in
	logic                                s_tlast = 1'b0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [fir20_pkg::SAMPLE_BITS-1:0]   m_tdata;        // [15:0] sample_out
	logic                                m_tlast;

	// filter state as the testbench sees it
	logic [fir20_pkg::REG_BITS-1:0] tap_coefs [fir20_pkg::COEF_REGS] = '{default: '0};
	logic signed [fir20_pkg::SAMPLE_BITS-1:0] history [fir20_pkg::TAPS-1] =
		'{default: '0};

	audio_word_t samples_to_send[$];
	audio_word_t filtered_expected[$];

	int  mismatches = 0;
	int  words_sent = 0;
	int  results_checked = 0;
	int  coef_sets = 0;
	int  send_gap = 0;
	int  hold_cnt = 0;
	bit  idle_on = 1'b1;
	bit  steady = 1'b0;

	fir_filter_twenty_tap u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Sum of products over the current sample and the delay line, rounded half up,
	// shifted and clamped; the delay line then advances by one.
	function automatic logic [fir20_pkg::SAMPLE_BITS-1:0] fir_next_output(
		logic [fir20_pkg::SAMPLE_BITS-1:0] sample);
		longint                                   acc;
		longint                                   y;
		longint                                   hi;
		longint                                   lo;
		logic signed [fir20_pkg::COEF_BITS-1:0]   c;
		logic signed [fir20_pkg::SAMPLE_BITS-1:0] x;
		acc = 0;
		hi = (longint'(1) << (fir20_pkg::SAMPLE_BITS - 1)) - 1;
		lo = -(longint'(1) << (fir20_pkg::SAMPLE_BITS - 1));
		for (int k = 0; k < fir20_pkg::TAPS; k++) begin
			c = tap_coefs[k / fir20_pkg::COEFS_PER_REG]
				[(k % fir20_pkg::COEFS_PER_REG) * fir20_pkg::COEF_BITS +: fir20_pkg::COEF_BITS];
			x = (k == 0) ? sample : history[k - 1];
			acc += longint'(c) * longint'(x);
		end
		y = (acc + (longint'(1) << (fir20_pkg::FRAC_SHIFT - 1))) >>> fir20_pkg::FRAC_SHIFT;
		if (y > hi)
			y = hi;
		if (y < lo)
			y = lo;
		for (int k = fir20_pkg::TAPS - 2; k > 0; k--)
			history[k] = history[k - 1];
		history[0] = sample;
		return y[fir20_pkg::SAMPLE_BITS-1:0];
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("tb: mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic write_reg(int unsigned idx, logic [fir20_pkg::REG_BITS-1:0] value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= fir20_pkg::CFG_ADDR_BITS'(idx);
		cfg_data <= value;
		if (idx < fir20_pkg::COEF_REGS)
			tap_coefs[idx] = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_coefs(coef_style_t style);
		logic [fir20_pkg::REG_BITS-1:0]  word;
		logic [fir20_pkg::COEF_BITS-1:0] c;
		for (int r = 0; r < fir20_pkg::COEF_REGS; r++) begin
			word = '0;
			for (int k = 0; k < fir20_pkg::COEFS_PER_REG; k++) begin
				case (style)
					SET_IMPULSE: c = (r == REG_TAPS_0_3 && k == 0) ? 16'h7fff : 16'h0000;
					SET_HALF:    c = (r == REG_TAPS_0_3 && k == 0) ? 16'h4000 : 16'h0000;
					SET_MAX_POS: c = 16'h7fff;
					SET_MAX_NEG: c = 16'h8000;
					SET_GENTLE:  c = fir20_pkg::COEF_BITS'($urandom_range(0, 4095) - 2048);
					default:     c = fir20_pkg::COEF_BITS'($urandom());
				endcase
				word[k * fir20_pkg::COEF_BITS +: fir20_pkg::COEF_BITS] = c;
			end
			write_reg(r, word);
		end
		// writes past the last register must leave the taps alone
		for (int a = fir20_pkg::COEF_REGS; a < 2 ** fir20_pkg::CFG_ADDR_BITS; a++)
			write_reg(a, {$urandom(), $urandom()});
		coef_sets++;
	endtask

	task automatic queue_word(logic [fir20_pkg::SAMPLE_BITS-1:0] sample, logic last);
		audio_word_t w;
		w.sample = sample;
		w.last   = last;
		samples_to_send.push_back(w);
	endtask

	function automatic logic [fir20_pkg::SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			1, 2, 3: return fir20_pkg::SAMPLE_BITS'($urandom_range(0, 2047) - 1024);
			default: return fir20_pkg::SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// wait until every queued word has gone through, then let the pipeline empty
	task automatic settle();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || s_tvalid || filtered_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (samples_to_send.size() != 0) begin
				audio_word_t w;
				w = samples_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= w.sample;
				s_tlast  <= w.last;
				if (idle_on && !steady && $urandom_range(0, 3) == 0)
					send_gap <= $urandom_range(1, 11);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_cnt > 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (idle_on && !steady && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			hold_cnt <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		audio_word_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (filtered_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h", m_tdata));
				end else begin
					want = filtered_expected.pop_front();
					if (m_tdata !== want.sample)
						report_mismatch($sformatf("sample_out %h, want %h", m_tdata, want.sample));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("buffer_end_out %b, want %b", m_tlast, want.last));
					results_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				want.sample = fir_next_output(s_tdata);
				want.last   = s_tlast;
				filtered_expected.push_back(want);
				words_sent++;
			end
		end
	end

	initial begin
		coef_style_t random_styles[RANDOM_PHASES];
		int          n;
		random_styles = '{SET_GENTLE, SET_RANDOM, SET_GENTLE, SET_RANDOM, SET_GENTLE, SET_RANDOM};
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients still at reset: all outputs zero
		@(negedge clk);
		queue_word(16'h7fff, 1'b0);
		queue_word(16'h8000, 1'b1);
		queue_word(16'h1234, 1'b0);
		settle();

		// pass-through on tap zero
		load_coefs(SET_IMPULSE);
		@(negedge clk);
		queue_word(16'h7fff, 1'b1);
		queue_word(16'h8000, 1'b0);
		queue_word(16'h0000, 1'b1);
		queue_word(16'h0001, 1'b0);
		queue_word(16'hffff, 1'b1);
		settle();

		// clamp at both bounds
		load_coefs(SET_MAX_POS);
		@(negedge clk);
		repeat (3) queue_word(16'h7fff, 1'b0);
		repeat (3) queue_word(16'h8000, 1'b1);
		settle();

		load_coefs(SET_MAX_NEG);
		@(negedge clk);
		repeat (2) queue_word(16'h8000, 1'b0);
		repeat (2) queue_word(16'h7fff, 1'b1);
		settle();

		// half-way sums round toward plus infinity
		load_coefs(SET_HALF);
		@(negedge clk);
		queue_word(16'h0001, 1'b0);
		queue_word(16'hffff, 1'b0);
		queue_word(16'h0003, 1'b1);
		queue_word(16'hfffd, 1'b0);
		queue_word(16'h0000, 1'b1);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_coefs(random_styles[p]);
			@(negedge clk);
			idle_on = (p != 2);
			steady  = (p == RANDOM_PHASES - 1);
			n = $urandom_range(170, 200);
			repeat (n) queue_word(pick_sample(), $urandom_range(0, 7) == 0);
			settle();
		end

		$display("tb: %0d samples filtered under %0d coefficient sets, %0d results checked",
			words_sent, coef_sets, results_checked);
		$display("tb: covered zero, impulse, saturating, rounding and random taps with stalls");
		if (mismatches == 0 && filtered_expected.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400_000;
		$display("tb: failure");
		$finish;
	end

endmodule

[fir_filter_twenty_tap.f]
rtl/fir20_pkg.sv
rtl/fir20_ctrl.sv
rtl/fir20_dp.sv
rtl/fir_filter_twenty_tap.sv
tb/testbench.sv
